// ===== rtl/lcg_random_draw_unit_top_assert.svh =====
// assertion macros for the lcg random draw unit
// used by the controller; clock clk and reset arst_n are taken from the module that expands them
`ifndef LCG_RANDOM_DRAW_UNIT_TOP_ASSERT_SVH
`define LCG_RANDOM_DRAW_UNIT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define LRDU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LRDU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LRDU_ASSERT_IMPL(lbl, ante, cons, msg)
`define LRDU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lrdu_pkg.sv =====
// shared types and constants for the lcg random draw unit
// no dependencies
`timescale 1ns / 1ps
package lrdu_pkg;

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_INC = 32'd12345;
	localparam logic [31:0] WORD_RESET = 32'd1;

	typedef enum logic [2:0] {
		CMD_SEED  = 3'd0,
		CMD_RAW   = 3'd1,
		CMD_BOOL  = 3'd2,
		CMD_RANGE = 3'd3,
		CMD_RECT  = 3'd4,
		CMD_SIZE  = 3'd5
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP1,
		ST_MUL1,
		ST_ACC1,
		ST_ACC2,
		ST_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;         // capture operands of an accepted word
		logic load_size;    // operands follow the point in size rules
		logic seed;         // generator takes the seed value
		logic step;         // advance the generator once
		logic mul;          // span times draw into the product register
		logic mul_sel_y;    // use the y span
		logic set_draw;     // first value from the draw itself
		logic draw_bool;    // boolean form of the draw
		logic acc_first;    // first value from the product
		logic acc_second;   // second value from the product
		logic clear_second; // second value is zero
		logic load_out;     // move results into the output register
	} ctl_cmd_t;

endpackage

// ===== rtl/lcg_random_draw_unit_top.sv =====
// top level of the lcg random draw unit
// depends on lrdu_pkg, lrdu_ctrl and lrdu_dpath
`timescale 1ns / 1ps
// Random draw unit on the 32-bit linear congruential generator
// word = word * 1103515245 + 12345; each draw is bits 16 to 30 of the new word.
// The command travels in s_tuser. Items are worked one at a time. A seed leaves
// the block idle and ready for the next word. A raw or boolean draw steps the
// generator and loads the result register from the draw. A ranged integer
// also multiplies the span by the draw before the result register is loaded. A
// point does this for x and then for y after a second generator step. The work
// is the generator multiply followed by the shared span multiplier for each
// coordinate, and it is held only while a finished result waits for the output
// register to be free. The result sits in an output register, so the next word
// is accepted while it waits. Codes 6 and 7 are taken and dropped. The
// generator word resets to one.
module lcg_random_draw_unit_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // seed_value, x_low, x_high, y_low, y_high
	input  logic [2:0]   s_tuser,  // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // first_value, second_value, zero pad
);
	import lrdu_pkg::*;

	ctl_cmd_t           ctl;
	logic signed [32:0] first_value;
	logic signed [32:0] second_value;

	// sequencing
	lrdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.command   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	// arithmetic
	lrdu_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.seed_value   (s_tdata[31:0]),
		.x_low        (s_tdata[63:32]),
		.x_high       (s_tdata[95:64]),
		.y_low        (s_tdata[127:96]),
		.y_high       (s_tdata[159:128]),
		.first_value  (first_value),
		.second_value (second_value)
	);

	assign m_tdata = {6'd0, second_value, first_value};

endmodule

// ===== rtl/lrdu_dpath.sv =====
// datapath of the lcg random draw unit: generator word, span multiplier, result registers
// depends on lrdu_pkg
`timescale 1ns / 1ps
module lrdu_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  lrdu_pkg::ctl_cmd_t  ctl,
	input  logic [31:0]         seed_value,
	input  logic signed [31:0]  x_low,
	input  logic signed [31:0]  x_high,
	input  logic signed [31:0]  y_low,
	input  logic signed [31:0]  y_high,
	output logic signed [32:0]  first_value,
	output logic signed [32:0]  second_value
);
	import lrdu_pkg::*;

	logic [31:0]        word_q;
	logic signed [31:0] lo_x_q;
	logic signed [31:0] lo_y_q;
	logic signed [33:0] span_x_q;
	logic signed [33:0] span_y_q;
	logic signed [49:0] prod_q;
	logic signed [32:0] first_q;
	logic signed [32:0] second_q;
	logic signed [32:0] out_first_q;
	logic signed [32:0] out_second_q;

	logic [14:0]        draw;
	logic signed [33:0] span_x_d;
	logic signed [33:0] span_y_d;
	logic signed [33:0] mul_span;
	logic signed [49:0] prod_d;
	logic signed [49:0] biased;
	logic signed [34:0] quot;
	logic signed [35:0] sum_d;
	logic signed [31:0] acc_lo;

	// draw is bits 16 to 30 of the generator word
	assign draw = word_q[30:16];

	// span = max - min + 1 without wrap; for a size it is the size itself
	always_comb begin
		if (ctl.load_size) begin
			span_x_d = {{2{x_high[31]}}, x_high};
			span_y_d = {{2{y_high[31]}}, y_high};
		end else begin
			span_x_d = {{2{x_high[31]}}, x_high} - {{2{x_low[31]}}, x_low} + 34'sd1;
			span_y_d = {{2{y_high[31]}}, y_high} - {{2{y_low[31]}}, y_low} + 34'sd1;
		end
	end

	// shared span multiplier
	assign mul_span = ctl.mul_sel_y ? span_y_q : span_x_q;
	assign prod_d   = mul_span * $signed({1'b0, draw});

	// shift right by 15 with truncation toward zero, then add the minimum
	assign biased = prod_q + (prod_q[49] ? 50'sd32767 : 50'sd0);
	assign quot   = 35'(biased >>> 15);
	assign acc_lo = ctl.acc_second ? lo_y_q : lo_x_q;
	assign sum_d  = {{4{acc_lo[31]}}, acc_lo} + {quot[34], quot};

	// generator word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= WORD_RESET;
		end else if (ctl.seed) begin
			word_q <= seed_value;
		end else if (ctl.step) begin
			word_q <= word_q * LCG_MUL + LCG_INC;
		end
	end

	// operand capture, product and results
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lo_x_q   <= ctl.load_size ? 32'sd0 : x_low;
			lo_y_q   <= ctl.load_size ? 32'sd0 : y_low;
			span_x_q <= span_x_d;
			span_y_q <= span_y_d;
		end
		if (ctl.mul) begin
			prod_q <= prod_d;
		end
		if (ctl.set_draw) begin
			first_q <= ctl.draw_bool ? {32'd0, ~word_q[30]} : {18'd0, draw};
		end else if (ctl.acc_first) begin
			first_q <= sum_d[32:0];
		end
		if (ctl.clear_second) begin
			second_q <= 33'sd0;
		end else if (ctl.acc_second) begin
			second_q <= sum_d[32:0];
		end
		if (ctl.load_out) begin
			out_first_q  <= first_q;
			out_second_q <= second_q;
		end
	end

	assign first_value  = out_first_q;
	assign second_value = out_second_q;

endmodule

// ===== rtl/lrdu_ctrl.sv =====
// controller of the lcg random draw unit: sequencing and stream handshakes
// depends on lrdu_pkg and lcg_random_draw_unit_top_assert.svh
`timescale 1ns / 1ps
`include "lcg_random_draw_unit_top_assert.svh"
module lrdu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          command,
	output logic                out_valid,
	input  logic                out_ready,
	output lrdu_pkg::ctl_cmd_t  ctl
);
	import lrdu_pkg::*;

	state_t    state_q;
	state_t    state_d;
	cmd_code_t cmd_q;
	logic      out_valid_q;
	logic      is_point;

	assign is_point  = (cmd_q == CMD_RECT) || (cmd_q == CMD_SIZE);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				cmd_q <= cmd_code_t'(command);
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load      = 1'b1;
					ctl.load_size = (command == CMD_SIZE);
					case (command) inside
						CMD_SEED: ctl.seed = 1'b1;
						CMD_RAW, CMD_BOOL, CMD_RANGE, CMD_RECT, CMD_SIZE: state_d = ST_STEP1;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_STEP1: begin
				ctl.step = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				ctl.mul = 1'b1;
				if (cmd_q == CMD_RAW || cmd_q == CMD_BOOL) begin
					ctl.set_draw     = 1'b1;
					ctl.draw_bool    = (cmd_q == CMD_BOOL);
					ctl.clear_second = 1'b1;
					state_d          = ST_OUT;
				end else begin
					// second draw for the y coordinate of a point
					ctl.step = is_point;
					state_d  = ST_ACC1;
				end
			end
			ST_ACC1: begin
				ctl.acc_first = 1'b1;
				if (is_point) begin
					ctl.mul       = 1'b1;
					ctl.mul_sel_y = 1'b1;
					state_d       = ST_ACC2;
				end else begin
					ctl.clear_second = 1'b1;
					state_d          = ST_OUT;
				end
			end
			ST_ACC2: begin
				ctl.acc_second = 1'b1;
				state_d        = ST_OUT;
			end
			ST_OUT: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`LRDU_ASSERT_NEXT(a_step_then_mul, state_q == ST_STEP1, state_q == ST_MUL1, "step not followed by multiply")
	`LRDU_ASSERT_IMPL(a_out_from_out_state, $rose(out_valid_q), $past(state_q) == ST_OUT, "result shown outside output state")
	`LRDU_ASSERT_NEXT(a_seed_no_work, in_valid && in_ready && command == CMD_SEED, state_q == ST_IDLE && !$rose(out_valid_q), "seed started work")

endmodule
